// File: rtl/rfwl_pkg.sv
package rfwl_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int BYTES_W    = 12;
    localparam int BIN_W      = 16;
    localparam int TOTAL_W    = 20;
    localparam int BACKLOG_W  = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // default window depth
    localparam int WINDOW_SLOTS_DEF = 16;

    // saturation limits
    localparam logic [BIN_W-1:0]   BIN_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BACKLOG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSPEND = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROTECT = 2'd3;

    // configuration reset values
    localparam logic [BACKLOG_W-1:0] BACKLOG_RST = 5'd5;
    localparam logic [BIN_W-1:0]     FLOOD_RST   = 16'd256;
    localparam logic [BIN_W-1:0]     SUSPEND_RST = 16'd10;
    localparam logic                 PROTECT_RST = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0]  now_seconds;
        logic [BYTES_W-1:0] reply_bytes;
        logic               direct_chat;
    } item_t;

    typedef struct packed {
        logic               send_reply;
        logic               flood_began;
        logic               flood_ended;
        logic [TOTAL_W-1:0] window_total;
    } result_t;

    typedef struct packed {
        logic [BACKLOG_W-1:0] backlog_seconds;
        logic [BIN_W-1:0]     flood_bytes;
        logic [BIN_W-1:0]     suspend_seconds;
        logic                 protect_enable;
    } cfg_t;

endpackage

// File: rtl/rfwl_in_stage.sv
module rfwl_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rfwl_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output rfwl_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    rfwl_pkg::item_t item_reg;

    // free when empty or when the held transaction moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/rfwl_core.sv
module rfwl_core #(
    parameter int WINDOW_SLOTS = rfwl_pkg::WINDOW_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rfwl_pkg::cfg_t   cfg,
    input  logic             advance,
    input  rfwl_pkg::item_t  item,
    output rfwl_pkg::result_t result
);

    localparam int BIN_W   = rfwl_pkg::BIN_W;
    localparam int TIME_W  = rfwl_pkg::TIME_W;
    localparam int TOTAL_W = rfwl_pkg::TOTAL_W;
    localparam int CNT_W   = $clog2(WINDOW_SLOTS + 1);
    localparam int LVL     = $clog2(WINDOW_SLOTS);
    localparam int PAD     = 1 << LVL;
    localparam int SUM_W   = (BIN_W + LVL > TOTAL_W) ? BIN_W + LVL : TOTAL_W;

    logic [TIME_W-1:0] last_reply_time_reg;
    logic [TIME_W-1:0] last_reply_time_next;
    logic [TIME_W-1:0] suspend_start_reg;
    logic [TIME_W-1:0] suspend_start_next;
    logic [BIN_W-1:0]  bins_reg  [WINDOW_SLOTS];
    logic [BIN_W-1:0]  bins_next [WINDOW_SLOTS];

    logic [CNT_W-1:0]              n_slots;
    logic [TIME_W-1:0]             delta;
    logic                          clear_all;
    logic [CNT_W-1:0]              shift_amt;
    logic [WINDOW_SLOTS*BIN_W-1:0] bins_flat;
    logic [WINDOW_SLOTS*BIN_W-1:0] bins_shifted;
    logic [BIN_W:0]                slot0_sum;
    logic [SUM_W-1:0]              node [2*PAD];
    logic [TOTAL_W-1:0]            total;
    logic                          flood_hit;
    logic [TIME_W-1:0]             susp_cand;
    logic [TIME_W:0]               susp_end;
    logic                          suppressing;
    logic                          was_suppressing;
    logic                          send;
    logic                          counts;

    // active slot count, clamped to 1..WINDOW_SLOTS
    always_comb begin
        if (cfg.backlog_seconds == '0) begin
            n_slots = CNT_W'(1);
        end else if (32'(cfg.backlog_seconds) > 32'(WINDOW_SLOTS)) begin
            n_slots = CNT_W'(WINDOW_SLOTS);
        end else begin
            n_slots = CNT_W'(cfg.backlog_seconds);
        end
    end

    // seconds since the last reply; a clock going backwards counts as no gap
    always_comb begin
        if (last_reply_time_reg != '0 && item.now_seconds > last_reply_time_reg) begin
            delta = item.now_seconds - last_reply_time_reg;
        end else begin
            delta = '0;
        end
        clear_all = delta >= TIME_W'(n_slots);
        shift_amt = clear_all ? '0 : delta[CNT_W-1:0];
    end

    // age the window: slots move to older indices by the gap
    always_comb begin
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            bins_flat[i*BIN_W +: BIN_W] = bins_reg[i];
        end
        bins_shifted = bins_flat << (shift_amt * BIN_W);
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            if (i < int'(n_slots)) begin
                bins_next[i] = clear_all ? '0 : bins_shifted[i*BIN_W +: BIN_W];
            end else begin
                bins_next[i] = bins_reg[i];
            end
        end
        // newest slot takes the reply, saturating
        slot0_sum = {1'b0, bins_next[0]} + (BIN_W+1)'(item.reply_bytes);
        if (slot0_sum[BIN_W]) begin
            bins_next[0] = rfwl_pkg::BIN_MAX;
        end else begin
            bins_next[0] = slot0_sum[BIN_W-1:0];
        end
    end

    // adder tree over the active slots
    always_comb begin
        node[0] = '0;
        for (int i = 0; i < PAD; i++) begin
            if (i < WINDOW_SLOTS && i < int'(n_slots)) begin
                node[PAD+i] = SUM_W'(bins_next[i]);
            end else begin
                node[PAD+i] = '0;
            end
        end
        for (int k = PAD - 1; k >= 1; k--) begin
            node[k] = node[2*k] + node[2*k+1];
        end
        if (node[1] > SUM_W'(rfwl_pkg::TOTAL_MAX)) begin
            total = rfwl_pkg::TOTAL_MAX;
        end else begin
            total = node[1][TOTAL_W-1:0];
        end
    end

    // suspension decision
    always_comb begin
        flood_hit       = total >= TOTAL_W'(cfg.flood_bytes);
        susp_cand       = flood_hit ? item.now_seconds : suspend_start_reg;
        susp_end        = {1'b0, susp_cand} + (TIME_W+1)'(cfg.suspend_seconds);
        suppressing     = (susp_cand != '0) && ({1'b0, item.now_seconds} <= susp_end);
        send            = !cfg.protect_enable || !suppressing;
        was_suppressing = suspend_start_reg != '0;
        counts          = (item.reply_bytes != '0) && !item.direct_chat;

        suspend_start_next   = send ? '0 : susp_cand;
        last_reply_time_next = item.now_seconds;
    end

    // result for the current transaction
    always_comb begin
        result = '0;
        if (item.reply_bytes != '0) begin
            if (item.direct_chat) begin
                result.send_reply = 1'b1;
            end else begin
                result.send_reply   = send;
                result.flood_began  = cfg.protect_enable && suppressing && !was_suppressing;
                result.flood_ended  = cfg.protect_enable && !suppressing && was_suppressing;
                result.window_total = total;
            end
        end
    end

    // limiter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reply_time_reg <= '0;
            suspend_start_reg   <= '0;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                bins_reg[i] <= '0;
            end
        end else if (advance && counts) begin
            last_reply_time_reg <= last_reply_time_next;
            suspend_start_reg   <= suspend_start_next;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                bins_reg[i] <= bins_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    // a counted reply records its time
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && counts |=> last_reply_time_reg == $past(item.now_seconds))
        else $error("last reply time not updated");

    // the newest slot holds at least the bytes just added
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && counts |=> bins_reg[0] != '0)
        else $error("newest slot empty after a counted reply");

    // a flood start always withholds the reply
    assert property (@(posedge aclk) disable iff (!aresetn)
        result.flood_began |-> !result.send_reply && !result.flood_ended)
        else $error("flood start with reply sent");

    // a sent reply leaves no suspension behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && counts && result.send_reply |=> suspend_start_reg == '0)
        else $error("suspension kept after a sent reply");
`endif

endmodule

// File: rtl/rfwl_out_stage.sv
module rfwl_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  rfwl_pkg::result_t result,
    output logic              load_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output rfwl_pkg::result_t m_result
);

    logic              valid_reg;
    logic              valid_next;
    rfwl_pkg::result_t result_reg;

    // room when empty or when the held transaction leaves this cycle
    assign load_ok    = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result capture
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// File: rtl/reply_flood_window_limiter.sv
// Reply flood limiter: each input transaction is one pending reply (time in
// seconds, length in bytes, direct-chat flag) and yields exactly one result
// transaction telling whether to send it, whether a flood suspension began or
// ended, and the window byte total. Per-second byte counts are kept in
// WINDOW_SLOTS registers; on each reply they are aged by the seconds since the
// previous reply (barrel shift), the reply is added to the newest slot and
// the active slots are summed by an adder tree, all combinationally between the
// input register and the result register. The block takes one transaction
// per clock unless the output stalls on m_ready, which holds both registers.
// Direct-chat and zero-length replies do not touch the limiter state.
// Configuration registers (backlog_seconds, flood_bytes, suspend_seconds,
// protect_enable at indexes 0 to 3) may be written only while idle.
module reply_flood_window_limiter #(
    parameter int WINDOW_SLOTS = rfwl_pkg::WINDOW_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rfwl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rfwl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rfwl_pkg::TIME_W-1:0]        s_now_seconds,
    input  logic [rfwl_pkg::BYTES_W-1:0]       s_reply_bytes,
    input  logic                               s_direct_chat,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_send_reply,
    output logic                               m_flood_began,
    output logic                               m_flood_ended,
    output logic [rfwl_pkg::TOTAL_W-1:0]       m_window_total
);

    rfwl_pkg::cfg_t    cfg_reg;
    rfwl_pkg::item_t   s_item;
    rfwl_pkg::item_t   item;
    rfwl_pkg::result_t result;
    rfwl_pkg::result_t m_result;
    logic              item_valid;
    logic              load_ok;
    logic              advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.backlog_seconds <= rfwl_pkg::BACKLOG_RST;
            cfg_reg.flood_bytes     <= rfwl_pkg::FLOOD_RST;
            cfg_reg.suspend_seconds <= rfwl_pkg::SUSPEND_RST;
            cfg_reg.protect_enable  <= rfwl_pkg::PROTECT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rfwl_pkg::REG_BACKLOG: begin
                    cfg_reg.backlog_seconds <= cfg_wdata[rfwl_pkg::BACKLOG_W-1:0];
                end
                rfwl_pkg::REG_FLOOD: begin
                    cfg_reg.flood_bytes <= cfg_wdata;
                end
                rfwl_pkg::REG_SUSPEND: begin
                    cfg_reg.suspend_seconds <= cfg_wdata;
                end
                rfwl_pkg::REG_PROTECT: begin
                    cfg_reg.protect_enable <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_item.now_seconds = s_now_seconds;
    assign s_item.reply_bytes = s_reply_bytes;
    assign s_item.direct_chat = s_direct_chat;

    // a held transaction moves on when the result register has room
    assign advance = item_valid && load_ok;

    rfwl_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rfwl_core #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    rfwl_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .load_ok  (load_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_send_reply   = m_result.send_reply;
    assign m_flood_began  = m_result.flood_began;
    assign m_flood_ended  = m_result.flood_ended;
    assign m_window_total = m_result.window_total;

endmodule
